FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SRSB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("srsb assertion failed");

// Clocked assertion that also holds during reset.
`define SRSB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("srsb assertion failed");

`endif

FILE: hdl/srsb_pkg.sv
// Package: shared types and constants of the RRIP stream-bypass replacement policy.
`default_nettype none
package srsb_pkg;

  localparam int unsigned DEF_SETS          = 2048;
  localparam int unsigned DEF_WAYS          = 16;
  localparam int unsigned DEF_SIG_ENTRIES   = 256;
  localparam int unsigned DEF_LEADERS       = 64;
  localparam int unsigned DEF_SELECTOR_BITS = 10;
  localparam int unsigned DEF_ADDR_BITS     = 48;

  localparam int unsigned SCORE_W  = 6;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned SELTH_W  = 10;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX    = 6'd63;
  localparam logic [CNT_W-1:0]   COUNTER_MAX  = 6'd63;
  localparam logic [CNT_W-1:0]   COUNTER_INIT = 6'd32;
  localparam logic [1:0]         AGE_MAX      = 2'd3;
  localparam logic [1:0]         AGE_INIT     = 2'd2;
  localparam logic [1:0]         AGE_HOT      = 2'd0;

  localparam logic [5:0]         STREAM_TH_INIT = 6'd48;
  localparam logic [5:0]         INSERT_TH_INIT = 6'd32;
  localparam logic [SELTH_W-1:0] SEL_TH_INIT    = 10'd512;

  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_TH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSERT_TH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_TH    = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/srsb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module srsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/ship_rrip_stream_bypass_policy_top.sv
// RRIP replacement policy with reuse counters per PC signature, a per-set
// stride stream detector and set dueling for streaming bypass. On accept the
// set row and the signature counter are read from their RAMs, and in the
// execute state they are computed and written back; a victim item waits in
// that state while the output register holds a result not yet taken. No new
// item is accepted until the last one leaves the execute state. After reset a
// clearing pass writes the reset row to every entry, during which no item is
// accepted; configuration writes are taken at any time.
// SETS and SIG_ENTRIES must be powers of two.
`default_nettype none
module ship_rrip_stream_bypass_policy_top #(
  parameter int unsigned SETS          = srsb_pkg::DEF_SETS,
  parameter int unsigned WAYS          = srsb_pkg::DEF_WAYS,
  parameter int unsigned SIG_ENTRIES   = srsb_pkg::DEF_SIG_ENTRIES,
  parameter int unsigned LEADERS       = srsb_pkg::DEF_LEADERS,
  parameter int unsigned SELECTOR_BITS = srsb_pkg::DEF_SELECTOR_BITS,
  parameter int unsigned ADDR_BITS     = srsb_pkg::DEF_ADDR_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_command,
  input  wire logic [10:0]                      in_set_index,
  input  wire logic [3:0]                       in_way_index,
  input  wire logic [ADDR_BITS-1:0]             in_block_address,
  input  wire logic [7:0]                       in_pc_signature,
  input  wire logic                             in_hit_flag,
  input  wire logic [15:0]                      in_valid_mask,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [3:0]                            out_victim_way,
  input  wire logic                             cfg_we,
  input  wire logic [srsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srsb_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int unsigned SET_BITS = $clog2(SETS);
  localparam int unsigned SIG_BITS = $clog2(SIG_ENTRIES);
  localparam int unsigned CLR_DEPTH = (SETS > SIG_ENTRIES) ? SETS : SIG_ENTRIES;
  localparam int unsigned CLR_BITS = $clog2(CLR_DEPTH);
  localparam int unsigned SC_W = srsb_pkg::SCORE_W;
  localparam int unsigned PA_LO = SC_W;
  localparam int unsigned ST_LO = PA_LO + ADDR_BITS;
  localparam int unsigned AG_LO = ST_LO + ADDR_BITS + 1;
  localparam int unsigned ROW_W = AG_LO + 2 * WAYS;
  localparam int unsigned CW = srsb_pkg::CNT_W;
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_INIT =
    SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);
  localparam logic [ROW_W-1:0] ROW_INIT = {{WAYS{srsb_pkg::AGE_INIT}},
                                           {(ROW_W - 2 * WAYS){1'b0}}};

  srsb_pkg::state_t state_r, state_nxt;
  logic [CLR_BITS-1:0]      clr_r, clr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [3:0]               out_way_r, out_way_nxt;
  logic [SELECTOR_BITS-1:0] sel_r, sel_nxt;
  logic [5:0]               stream_th_r, insert_th_r;
  logic [srsb_pkg::SELTH_W-1:0] sel_th_r;

  // captured item
  logic                 cmd_r, hit_r;
  logic [SET_BITS-1:0]  set_r;
  logic [SIG_BITS-1:0]  sig_r;
  logic [3:0]           way_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [15:0]          mask_r;
  logic                 byp_lead_r, norm_lead_r;

  logic [SET_BITS-1:0] in_set, set_raddr, set_waddr;
  logic [SIG_BITS-1:0] in_sig, sig_raddr, sig_waddr;
  logic [ROW_W-1:0]    set_rdata, set_wdata;
  logic [CW-1:0]       sig_rdata, sig_wdata;
  logic                set_we, sig_we;
  logic                accept;

  assign in_set = SET_BITS'(32'(in_set_index));
  assign in_sig = SIG_BITS'(32'(in_pc_signature));
  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == srsb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_victim_way = out_way_r;

  // leader classification of the incoming set
  logic [LEADERS-1:0] lead_hit;
  for (genvar i = 0; i < LEADERS; i++) begin : g_lead
    localparam int unsigned LS = (i * SETS) / LEADERS;
    assign lead_hit[i] = (32'(in_set) == LS);
  end
  logic in_byp_lead, in_norm_lead;
  assign in_byp_lead  = |lead_hit[LEADERS/2-1:0];
  assign in_norm_lead = !in_byp_lead && (|lead_hit[LEADERS-1:LEADERS/2]);

  assign set_raddr = (state_r == srsb_pkg::ST_IDLE) ? in_set : set_r;
  assign sig_raddr = (state_r == srsb_pkg::ST_IDLE) ? in_sig : sig_r;

  srsb_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_set_ram (
    .clk(clk), .we(set_we), .waddr(set_waddr), .wdata(set_wdata),
    .raddr(set_raddr), .rdata(set_rdata)
  );

  srsb_ram #(.WIDTH(CW), .DEPTH(SIG_ENTRIES)) u_sig_ram (
    .clk(clk), .we(sig_we), .waddr(sig_waddr), .wdata(sig_wdata),
    .raddr(sig_raddr), .rdata(sig_rdata)
  );

  // row fields
  logic [SC_W-1:0]      score;
  logic [ADDR_BITS-1:0] prev;
  logic [ADDR_BITS:0]   stride, diff;
  logic [1:0]           ages [WAYS];
  assign score  = set_rdata[SC_W-1:0];
  assign prev   = set_rdata[ST_LO-1:PA_LO];
  assign stride = set_rdata[AG_LO-1:ST_LO];
  for (genvar w = 0; w < WAYS; w++) begin : g_age
    assign ages[w] = set_rdata[AG_LO+2*w +: 2];
  end
  assign diff = {1'b0, addr_r} - {1'b0, prev};

  // victim search
  logic       any_invalid, any3, any2, any1;
  logic [3:0] inv_way, top_way;
  logic [1:0] top, add;
  logic [2*WAYS-1:0] aged;
  always_comb begin
    any_invalid = 1'b0;
    inv_way = '0;
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (w < 16 && !mask_r[w]) begin
        any_invalid = 1'b1;
        inv_way = 4'(w);
      end
      if (ages[w] == 2'd3) any3 = 1'b1;
      if (ages[w] == 2'd2) any2 = 1'b1;
      if (ages[w] == 2'd1) any1 = 1'b1;
    end
    top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
    add = srsb_pkg::AGE_MAX - top;
    top_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      aged[2*w +: 2] = ages[w] + add;
      if (ages[w] == top) top_way = 4'(w);
    end
  end

  // update path
  logic [SC_W-1:0] score_new;
  logic [CW-1:0]   cnt_new;
  logic            streaming, bypass, way_ok;
  logic [1:0]      ins_age;
  logic [2*WAYS-1:0] ages_upd;
  always_comb begin
    score_new = score;
    if (prev != '0) begin
      if (diff == stride && diff != '0) begin
        if (score < srsb_pkg::SCORE_MAX) score_new = score + 1'b1;
      end else if (score != '0) begin
        score_new = score - 1'b1;
      end
    end
    cnt_new = sig_rdata;
    if (hit_r) begin
      if (sig_rdata < srsb_pkg::COUNTER_MAX) cnt_new = sig_rdata + 1'b1;
    end else if (sig_rdata != '0) begin
      cnt_new = sig_rdata - 1'b1;
    end
    sel_nxt = sel_r;
    if (state_r == srsb_pkg::ST_EXEC && cmd_r == srsb_pkg::CMD_UPDATE && !hit_r) begin
      if (byp_lead_r && sel_r != SEL_MAX) sel_nxt = sel_r + 1'b1;
      else if (norm_lead_r && sel_r != '0) sel_nxt = sel_r - 1'b1;
    end
    streaming = (score_new >= stream_th_r);
    priority if (byp_lead_r) bypass = streaming;
    else if (norm_lead_r) bypass = 1'b0;
    else bypass = streaming && (16'(sel_nxt) >= 16'(sel_th_r));
    if (hit_r) ins_age = srsb_pkg::AGE_HOT;
    else if (bypass) ins_age = srsb_pkg::AGE_MAX;
    else if (cnt_new >= insert_th_r) ins_age = srsb_pkg::AGE_HOT;
    else ins_age = srsb_pkg::AGE_INIT;
    way_ok = (32'(way_r) < WAYS);
    for (int w = 0; w < WAYS; w++) begin
      ages_upd[2*w +: 2] = (way_ok && 32'(way_r) == w) ? ins_age : ages[w];
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_way_nxt = out_way_r;
    set_we = 1'b0;
    sig_we = 1'b0;
    set_waddr = set_r;
    sig_waddr = sig_r;
    set_wdata = ROW_INIT;
    sig_wdata = srsb_pkg::COUNTER_INIT;
    unique case (state_r)
      srsb_pkg::ST_CLEAR: begin
        set_we = (32'(clr_r) < SETS);
        sig_we = (32'(clr_r) < SIG_ENTRIES);
        set_waddr = SET_BITS'(32'(clr_r));
        sig_waddr = SIG_BITS'(32'(clr_r));
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == CLR_DEPTH - 1) state_nxt = srsb_pkg::ST_IDLE;
      end
      srsb_pkg::ST_IDLE: begin
        if (accept) state_nxt = srsb_pkg::ST_EXEC;
      end
      srsb_pkg::ST_EXEC: begin
        if (cmd_r == srsb_pkg::CMD_VICTIM) begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_nxt = 1'b1;
            out_way_nxt = any_invalid ? inv_way : top_way;
            set_we = !any_invalid;
            set_wdata = {aged, stride, prev, score};
            state_nxt = srsb_pkg::ST_IDLE;
          end
        end else begin
          set_we = 1'b1;
          sig_we = 1'b1;
          set_wdata = {ages_upd, diff, addr_r, score_new};
          sig_wdata = cnt_new;
          state_nxt = srsb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srsb_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srsb_pkg::ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      sel_r <= SEL_INIT;
      stream_th_r <= srsb_pkg::STREAM_TH_INIT;
      insert_th_r <= srsb_pkg::INSERT_TH_INIT;
      sel_th_r <= srsb_pkg::SEL_TH_INIT;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r <= sel_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          srsb_pkg::CFG_STREAM_TH: stream_th_r <= cfg_wdata[5:0];
          srsb_pkg::CFG_INSERT_TH: insert_th_r <= cfg_wdata[5:0];
          srsb_pkg::CFG_SEL_TH:    sel_th_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_way_r <= out_way_nxt;
    if (accept) begin
      cmd_r <= in_command;
      hit_r <= in_hit_flag;
      set_r <= in_set;
      sig_r <= in_sig;
      way_r <= in_way_index;
      addr_r <= in_block_address;
      mask_r <= in_valid_mask;
      byp_lead_r <= in_byp_lead;
      norm_lead_r <= in_norm_lead;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/srsb_checker.sv
// Port-level checker for the replacement policy, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module srsb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_victim_way
);

  // a stalled result holds
  `SRSB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_victim_way))
  // clearing pass blocks input right after reset
  `SRSB_ASSERT_ALWAYS(a_clear_blocks, clk, !rst_n |=> !in_ready)
  // one item at a time: no transfer in the cycle after a transfer
  `SRSB_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready)

endmodule

bind ship_rrip_stream_bypass_policy_top srsb_checker u_srsb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_victim_way(out_victim_way)
);
`default_nettype wire

FILE: dv/ship_rrip_stream_bypass_policy_checker.sv
// Checker for the RRIP stream-bypass policy: predicts victim ways and compares transfers.
`timescale 1ns / 1ps
module ship_rrip_stream_bypass_policy_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic [10:0] in_set_index,
  input  logic [3:0]  in_way_index,
  input  logic [47:0] in_block_address,
  input  logic [7:0]  in_pc_signature,
  input  logic        in_hit_flag,
  input  logic [15:0] in_valid_mask,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_victim_way,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  output int          fail_count,
  output int          pending_victims
);

  logic [1:0]  age_tab [2048][16];
  logic [5:0]  score_tab [2048];
  logic [47:0] prev_addr_tab [2048];
  logic [48:0] prev_stride_tab [2048];
  logic [5:0]  reuse_tab [256];
  logic [9:0]  duel_sel;
  logic [5:0]  stream_th;
  logic [5:0]  insert_th;
  logic [9:0]  sel_th;
  logic [3:0]  victim_q[$];

  assign pending_victims = victim_q.size();

  // 0 bypass leader, 1 normal leader, 2 follower
  function automatic int leader_kind(input logic [10:0] s);
    if (s[4:0] != 0) return 2;
    return (s < 11'd1024) ? 0 : 1;
  endfunction

  task automatic apply_access();
    logic [10:0] s;
    logic [3:0]  w;
    logic [7:0]  sig;
    logic [48:0] stride;
    logic [1:0]  top;
    logic [1:0]  add;
    int kind;
    logic bypass;
    logic streaming;
    s = in_set_index;
    w = in_way_index;
    sig = in_pc_signature;
    if (in_command == srsb_pkg::CMD_VICTIM) begin
      for (int i = 0; i < 16; i++)
        if (!in_valid_mask[i]) begin
          victim_q = {victim_q, 4'(i)};
          return;
        end
      top = 0;
      for (int i = 0; i < 16; i++) if (age_tab[s][i] > top) top = age_tab[s][i];
      add = srsb_pkg::AGE_MAX - top;
      for (int i = 0; i < 16; i++) age_tab[s][i] = age_tab[s][i] + add;
      for (int i = 0; i < 16; i++)
        if (age_tab[s][i] == srsb_pkg::AGE_MAX) begin
          victim_q = {victim_q, 4'(i)};
          return;
        end
      victim_q = {victim_q, 4'd0};
      return;
    end
    stride = {1'b0, in_block_address} - {1'b0, prev_addr_tab[s]};
    if (prev_addr_tab[s] != 0) begin
      if (stride == prev_stride_tab[s] && stride != 0) begin
        if (score_tab[s] != srsb_pkg::SCORE_MAX) score_tab[s]++;
      end else if (score_tab[s] != 0) score_tab[s]--;
    end
    prev_addr_tab[s] = in_block_address;
    prev_stride_tab[s] = stride;
    if (in_hit_flag) begin
      if (reuse_tab[sig] != srsb_pkg::COUNTER_MAX) reuse_tab[sig]++;
      age_tab[s][w] = srsb_pkg::AGE_HOT;
    end else if (reuse_tab[sig] != 0) reuse_tab[sig]--;
    kind = leader_kind(s);
    if (!in_hit_flag) begin
      if (kind == 0 && duel_sel != 10'h3FF) duel_sel++;
      else if (kind == 1 && duel_sel != 0) duel_sel--;
    end
    streaming = score_tab[s] >= stream_th;
    if (kind == 0) bypass = streaming;
    else if (kind == 1) bypass = 1'b0;
    else bypass = (duel_sel >= sel_th) && streaming;
    if (!in_hit_flag)
      age_tab[s][w] = bypass ? srsb_pkg::AGE_MAX :
                      (reuse_tab[sig] >= insert_th ? srsb_pkg::AGE_HOT : srsb_pkg::AGE_INIT);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 2048; s++) begin
        for (int i = 0; i < 16; i++) age_tab[s][i] = srsb_pkg::AGE_INIT;
        score_tab[s] = 0;
        prev_addr_tab[s] = 0;
        prev_stride_tab[s] = 0;
      end
      for (int i = 0; i < 256; i++) reuse_tab[i] = srsb_pkg::COUNTER_INIT;
      duel_sel = srsb_pkg::SEL_TH_INIT;
      stream_th = srsb_pkg::STREAM_TH_INIT;
      insert_th = srsb_pkg::INSERT_TH_INIT;
      sel_th = srsb_pkg::SEL_TH_INIT;
      victim_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srsb_pkg::CFG_STREAM_TH: stream_th = cfg_wdata[5:0];
          srsb_pkg::CFG_INSERT_TH: insert_th = cfg_wdata[5:0];
          srsb_pkg::CFG_SEL_TH:    sel_th = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (victim_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected victim transfer: got %0d", out_victim_way);
        end else begin
          if (victim_q[0] !== out_victim_way) begin
            fail_count++;
            if (fail_count <= 10)
              $display("victim_way mismatch: expected %0d got %0d", victim_q[0], out_victim_way);
          end
          void'(victim_q.pop_front());
        end
      end
      if (in_valid && in_ready) apply_access();
    end
  end
endmodule

FILE: dv/ship_rrip_stream_bypass_policy_top_tb.sv
// Testbench top: drives stimulus and configuration, and reports the verdict.
`timescale 1ns / 1ps
module ship_rrip_stream_bypass_policy_top_tb;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_command = 0;
  logic [10:0] in_set_index = 0;
  logic [3:0]  in_way_index = 0;
  logic [47:0] in_block_address = 0;
  logic [7:0]  in_pc_signature = 0;
  logic        in_hit_flag = 0;
  logic [15:0] in_valid_mask = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [3:0]  out_victim_way;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = srsb_pkg::CFG_STREAM_TH;
  logic [9:0]  cfg_wdata = 0;
  int          fail_count;
  int          pending_victims;
  int          cycle_count = 0;
  bit          hold_req = 0;
  bit          hold_off = 0;
  bit          hold_done = 0;

  ship_rrip_stream_bypass_policy_top dut (.*);

  ship_rrip_stream_bypass_policy_checker checker_i (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls plus one long hold-off while the sender keeps pushing.
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= (gap_len() == 0);
  end

  initial begin
    wait (hold_req);
    @(negedge clk);
    hold_off = 1;
    repeat (300) @(negedge clk);
    hold_off = 0;
    hold_done = 1;
  end

  // Starts and ends at a falling edge; valid stays high after the transfer
  // until the next item or a gap.
  task automatic send(input logic cmd, input logic [10:0] s, input logic [3:0] w,
                      input logic [47:0] a, input logic [7:0] sig, input logic hit,
                      input logic [15:0] mask);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_set_index <= s;
    in_way_index <= w;
    in_block_address <= a;
    in_pc_signature <= sig;
    in_hit_flag <= hit;
    in_valid_mask <= mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_victims != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_item(input int phase);
    logic [10:0] s;
    logic [47:0] base;
    int r;
    int cnt;
    r = $urandom_range(0, 99);
    cnt = $urandom_range(3, 10);
    // Hot sets: leaders and a few followers, so streams build up.
    s = (r < 40) ? 11'($urandom_range(0, 63) * 32) : 11'($urandom_range(0, 7) * 97 + 1);
    if (r < 45)
      send(srsb_pkg::CMD_VICTIM, s, 0, 0, 0, 0,
           ($urandom_range(0, 1)) ? 16'hFFFF : 16'($urandom));
    else if (r < 85) begin
      base = 48'({$urandom, $urandom});
      for (int k = 0; k < cnt; k++)
        send(srsb_pkg::CMD_UPDATE, s, 4'($urandom), base + 48'(k * 64 * (phase + 1)),
             8'($urandom_range(0, 15)), $urandom_range(0, 3) == 0, 0);
    end else
      send(1'($urandom_range(0, 1)), 11'($urandom), 4'($urandom), 48'({$urandom, $urandom}),
           8'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    write_reg(srsb_pkg::CFG_STREAM_TH, 10'd2);
    // Directed: extremes, both commands, wrap of addresses.
    send(srsb_pkg::CMD_VICTIM, 11'd0, 0, 0, 0, 0, 16'hFFFF);
    send(srsb_pkg::CMD_VICTIM, 11'd2047, 0, 0, 0, 0, 16'h7FFF);
    send(srsb_pkg::CMD_VICTIM, 11'd5, 0, 0, 0, 0, 16'h0000);
    send(srsb_pkg::CMD_UPDATE, 11'd0, 4'd15, 48'hFFFF_FFFF_FFFF, 8'hFF, 1, 16'hFFFF);
    send(srsb_pkg::CMD_UPDATE, 11'd0, 4'd3, 48'h0, 8'hFF, 0, 0);
    send(srsb_pkg::CMD_UPDATE, 11'd0, 4'd3, 48'h0, 8'h00, 0, 0);
    for (int k = 1; k <= 6; k++)
      send(srsb_pkg::CMD_UPDATE, 11'd32, 4'd7, 48'(k * 4096), 8'h10, 0, 0);
    for (int k = 6; k >= 1; k--)
      send(srsb_pkg::CMD_UPDATE, 11'd1024, 4'd8, 48'(k * 4096), 8'h11, 0, 0);
    send(srsb_pkg::CMD_UPDATE, 11'd1025, 4'd2, 48'h8000, 8'h12, 1, 0);
    send(srsb_pkg::CMD_VICTIM, 11'd32, 0, 0, 0, 0, 16'hFFFF);
    send(srsb_pkg::CMD_VICTIM, 11'd1024, 0, 0, 0, 0, 16'hFFFF);
    send(srsb_pkg::CMD_VICTIM, 11'd0, 0, 0, 0, 0, 16'hFFFF);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(srsb_pkg::CFG_STREAM_TH, 10'd0);
                 write_reg(srsb_pkg::CFG_INSERT_TH, 10'd63);
                 write_reg(srsb_pkg::CFG_SEL_TH, 10'd0); end
        1: begin write_reg(srsb_pkg::CFG_STREAM_TH, 10'd63);
                 write_reg(srsb_pkg::CFG_INSERT_TH, 10'd0);
                 write_reg(srsb_pkg::CFG_SEL_TH, 10'd1023); end
        2: begin write_reg(srsb_pkg::CFG_STREAM_TH, 10'd3);
                 write_reg(srsb_pkg::CFG_INSERT_TH, 10'd30);
                 write_reg(srsb_pkg::CFG_SEL_TH, 10'd500); end
        default: begin write_reg(srsb_pkg::CFG_STREAM_TH, 10'd48);
                       write_reg(srsb_pkg::CFG_INSERT_TH, 10'd32);
                       write_reg(srsb_pkg::CFG_SEL_TH, 10'd512); end
      endcase
      // long receiver hold-off while this phase keeps offering items
      if (phase == 1) hold_req = 1;
      for (int n = 0; n < 30; n++) random_item(phase);
      drain();
    end
    wait (hold_done);
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_victims == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

FILE: ship_rrip_stream_bypass_policy_top.f
+incdir+hdl
hdl/srsb_pkg.sv
hdl/srsb_ram.sv
hdl/ship_rrip_stream_bypass_policy_top.sv
hdl/srsb_checker.sv
dv/ship_rrip_stream_bypass_policy_checker.sv
dv/ship_rrip_stream_bypass_policy_top_tb.sv
